[rtl/pixel_wavelength_poly_eval_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the pixel wavelength polynomial unit
// Concurrent checks that compile away when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef PIXEL_WAVELENGTH_POLY_EVAL_UNIT_DEFINES_SVH
`define PIXEL_WAVELENGTH_POLY_EVAL_UNIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define PWPE_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("pwpe: same-cycle check failed");
// next-cycle implication
`define PWPE_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("pwpe: next-cycle check failed");
`else
`define PWPE_ASSERT_IMP(lbl, clk, rst, a, c)
`define PWPE_ASSERT_NXT(lbl, clk, rst, a, c)
`endif

`endif

[rtl/pwpe_pkg.sv]
// ----------------------------------------------------------------------------
// pwpe_pkg
// Shared widths, constants and types of the wavelength polynomial unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pwpe_pkg;

  localparam int NUM_TERMS  = 5;
  localparam int MAX_CELLS  = 4096;
  localparam int NUM_COEFS  = 5;

  localparam int COEF_W     = 48;
  localparam int CELL_W     = 12;
  localparam int PIX_W      = 13;
  localparam int TERMS_W    = 3;
  localparam int TOL_W      = 24;
  localparam int CNT_W      = 13;
  localparam int X_W        = 14;
  localparam int PROD_W     = COEF_W + X_W;
  localparam int FRAC_SHIFT = 13;
  localparam int COEF_IDX_W = 3;

  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;

  localparam logic [TERMS_W-1:0] MIN_TERMS = 3'd2;
  localparam logic [TOL_W-1:0]   TOL_RESET = 24'd167772;
  localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [COEF_W-1:0]  S48_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0]  S48_MIN   = {1'b1, {(COEF_W-1){1'b0}}};

  // register map indexes
  localparam logic [REG_IDX_W-1:0] REG_COEF_0     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEF_1     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEF_2     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COEF_3     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COEF_4     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PIX_BASE   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_TERM_COUNT = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_TOLERANCE  = 3'd7;

  typedef struct packed {
    logic [NUM_COEFS-1:0][COEF_W-1:0] coef;
    logic [PIX_W-1:0]                 pix_base;
    logic [TERMS_W-1:0]               term_count;
    logic [TOL_W-1:0]                 tolerance;
  } cfg_t;

  typedef struct packed {
    logic                  load;
    logic                  mul;
    logic                  add;
    logic                  fin;
    logic [COEF_IDX_W-1:0] coef_sel;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/pwpe_if.sv]
// ----------------------------------------------------------------------------
// pwpe channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pwpe_req_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic [pwpe_pkg::CELL_W-1:0]       cell_req;
  logic signed [pwpe_pkg::COEF_W-1:0] ref_wavelength;
  logic                              last;

  modport source (output valid, output opcode, output cell_req, output ref_wavelength,
                  output last, input ready);
  modport sink   (input valid, input opcode, input cell_req, input ref_wavelength,
                  input last, output ready);
endinterface

interface pwpe_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [pwpe_pkg::COEF_W-1:0] wavelength;
  logic                               mismatch;
  logic [pwpe_pkg::CNT_W-1:0]         diff_count;
  logic                               status;
  logic                               run_end;

  modport source (output valid, output wavelength, output mismatch, output diff_count,
                  output status, output run_end, input ready);
  modport sink   (input valid, input wavelength, input mismatch, input diff_count,
                  input status, input run_end, output ready);
endinterface

`default_nettype wire

[rtl/pwpe_regs.sv]
// ----------------------------------------------------------------------------
// pwpe_regs
// APB register file holding coefficients, pixel base, term count, tolerance.
// ----------------------------------------------------------------------------
`default_nettype none

module pwpe_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [pwpe_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [pwpe_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [pwpe_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                     pready,
  output pwpe_pkg::cfg_t                           cfg
);

  logic [pwpe_pkg::REG_IDX_W-1:0] idx;
  logic                           wr_en;

  // registers sit on 8-byte boundaries
  assign idx    = paddr[pwpe_pkg::APB_ADDR_W-1:3];
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef       <= '0;
      cfg.pix_base   <= '0;
      cfg.term_count <= '0;
      cfg.tolerance  <= pwpe_pkg::TOL_RESET;
    end else if (wr_en) begin
      case (idx) inside
        pwpe_pkg::REG_COEF_0, pwpe_pkg::REG_COEF_1, pwpe_pkg::REG_COEF_2,
        pwpe_pkg::REG_COEF_3, pwpe_pkg::REG_COEF_4: begin
          cfg.coef[idx] <= pwdata[pwpe_pkg::COEF_W-1:0];
        end
        pwpe_pkg::REG_PIX_BASE: begin
          cfg.pix_base <= pwdata[pwpe_pkg::PIX_W-1:0];
        end
        pwpe_pkg::REG_TERM_COUNT: begin
          cfg.term_count <= pwdata[pwpe_pkg::TERMS_W-1:0];
        end
        pwpe_pkg::REG_TOLERANCE: begin
          cfg.tolerance <= pwdata[pwpe_pkg::TOL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx) inside
      pwpe_pkg::REG_COEF_0, pwpe_pkg::REG_COEF_1, pwpe_pkg::REG_COEF_2,
      pwpe_pkg::REG_COEF_3, pwpe_pkg::REG_COEF_4: begin
        prdata = {{(pwpe_pkg::APB_DATA_W-pwpe_pkg::COEF_W){1'b0}}, cfg.coef[idx]};
      end
      pwpe_pkg::REG_PIX_BASE: begin
        prdata = {{(pwpe_pkg::APB_DATA_W-pwpe_pkg::PIX_W){1'b0}}, cfg.pix_base};
      end
      pwpe_pkg::REG_TERM_COUNT: begin
        prdata = {{(pwpe_pkg::APB_DATA_W-pwpe_pkg::TERMS_W){1'b0}}, cfg.term_count};
      end
      pwpe_pkg::REG_TOLERANCE: begin
        prdata = {{(pwpe_pkg::APB_DATA_W-pwpe_pkg::TOL_W){1'b0}}, cfg.tolerance};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/pwpe_ctrl.sv]
// ----------------------------------------------------------------------------
// pwpe_ctrl
// Sequencer: load, then multiply/add per Horner step, then finish.
// ----------------------------------------------------------------------------
`default_nettype none

module pwpe_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output pwpe_pkg::cmd_t      cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_ADD  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam logic [pwpe_pkg::COEF_IDX_W-1:0] STEP_FIRST =
    pwpe_pkg::COEF_IDX_W'(pwpe_pkg::NUM_TERMS - 2);

  logic [1:0]                        state, state_next;
  logic [pwpe_pkg::COEF_IDX_W-1:0]   step, step_next;
  logic                              out_valid_next;
  logic                              fin_go;

  assign in_ready = (state == S_IDLE);
  // result register must be free before it is overwritten
  assign fin_go   = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    state_next     = state;
    step_next      = step;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.coef_sel   = step;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          step_next  = STEP_FIRST;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        if (step == '0) begin
          state_next = S_FIN;
        end else begin
          step_next  = step - 1'b1;
          state_next = S_MUL;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          cmd.fin        = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

[rtl/pwpe_dp.sv]
// ----------------------------------------------------------------------------
// pwpe_dp
// Datapath: shared 48x14 multiplier, round/add/saturate, verify compare,
// mismatch counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pwpe_dp (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire pwpe_pkg::cmd_t                        cmd,
  input  wire pwpe_pkg::cfg_t                        cfg,
  input  wire logic                                  opcode,
  input  wire logic        [pwpe_pkg::CELL_W-1:0]    cell_req,
  input  wire logic signed [pwpe_pkg::COEF_W-1:0]    ref_wavelength,
  input  wire logic                                  last,
  output logic signed      [pwpe_pkg::COEF_W-1:0]    wavelength,
  output logic                                       mismatch,
  output logic             [pwpe_pkg::CNT_W-1:0]     diff_count,
  output logic                                       status,
  output logic                                       run_end
);

  localparam int CW = pwpe_pkg::COEF_W;
  localparam int SH_W = pwpe_pkg::PROD_W - pwpe_pkg::FRAC_SHIFT;
  localparam int EW = CW + 2;
  localparam logic signed [pwpe_pkg::PROD_W-1:0] RND_HALF =
    pwpe_pkg::PROD_W'(1) << (pwpe_pkg::FRAC_SHIFT - 1);

  logic signed [CW-1:0]                acc;
  logic signed [pwpe_pkg::X_W-1:0]     x;
  logic signed [pwpe_pkg::PROD_W-1:0]  prod;
  logic                                op_q;
  logic signed [CW-1:0]                ref_q;
  logic                                last_q;
  logic        [pwpe_pkg::CNT_W-1:0]   cnt;

  logic        [pwpe_pkg::CELL_W-1:0]  cell_sat;
  logic signed [pwpe_pkg::X_W-1:0]     x_next;
  logic signed [pwpe_pkg::PROD_W-1:0]  rnd;
  logic signed [SH_W-1:0]              sh;
  logic signed [EW-1:0]                sh_ext, c_ext, sum;
  logic        [CW-1:0]                c_sel;
  logic                                ovf;
  logic signed [CW-1:0]                acc_add;
  logic signed [EW-1:0]                acc_ext, ref_ext, tol_ext, d_pos, d_neg;
  logic                                fail, mis, out_of_tol;
  logic        [pwpe_pkg::CNT_W-1:0]   cnt_upd;

  always_comb begin
    if ((pwpe_pkg::CELL_W + 1)'(cell_req) >= (pwpe_pkg::CELL_W + 1)'(pwpe_pkg::MAX_CELLS)) begin
      cell_sat = pwpe_pkg::CELL_W'(pwpe_pkg::MAX_CELLS - 1);
    end else begin
      cell_sat = cell_req;
    end
    x_next = $signed({2'b00, cell_sat}) + $signed({cfg.pix_base[pwpe_pkg::PIX_W-1], cfg.pix_base});

    // round to nearest, ties up, then floor shift
    rnd     = prod + RND_HALF;
    sh      = rnd[pwpe_pkg::PROD_W-1:pwpe_pkg::FRAC_SHIFT];
    c_sel   = cfg.coef[cmd.coef_sel];
    sh_ext  = {sh[SH_W-1], sh};
    c_ext   = {{2{c_sel[CW-1]}}, c_sel};
    sum     = sh_ext + c_ext;
    ovf     = (sum[EW-1:CW-1] != 3'b000) && (sum[EW-1:CW-1] != 3'b111);
    if (ovf) begin
      acc_add = sum[EW-1] ? pwpe_pkg::S48_MIN : pwpe_pkg::S48_MAX;
    end else begin
      acc_add = sum[CW-1:0];
    end

    acc_ext    = {{2{acc[CW-1]}}, acc};
    ref_ext    = {{2{ref_q[CW-1]}}, ref_q};
    tol_ext    = {{(EW-pwpe_pkg::TOL_W){1'b0}}, cfg.tolerance};
    d_pos      = ref_ext - acc_ext;
    d_neg      = acc_ext - ref_ext;
    out_of_tol = (d_pos > tol_ext) || (d_neg > tol_ext);

    fail    = cfg.term_count < pwpe_pkg::MIN_TERMS;
    mis     = !fail && op_q && out_of_tol;
    cnt_upd = cnt + pwpe_pkg::CNT_W'(mis && (cnt != pwpe_pkg::CNT_MAX));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= opcode;
      ref_q  <= ref_wavelength;
      last_q <= last;
      x      <= x_next;
      acc    <= cfg.coef[pwpe_pkg::NUM_TERMS-1];
    end else if (cmd.add) begin
      acc <= acc_add;
    end
    if (cmd.mul) begin
      prod <= acc * x;
    end
    if (cmd.fin) begin
      wavelength <= fail ? '0 : acc;
      mismatch   <= mis;
      diff_count <= cnt_upd;
      status     <= fail;
      run_end    <= last_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.fin) begin
      cnt <= last_q ? '0 : cnt_upd;
    end
  end

endmodule

`default_nettype wire

[rtl/pixel_wavelength_poly_eval_unit.sv]
// ----------------------------------------------------------------------------
// pixel_wavelength_poly_eval_unit
// Degree-4 calibration polynomial over detector cells with verify compare.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item per detector cell: opcode (compute/verify),
//   cell_req, ref_wavelength and last. rsp returns one item per request:
//   saturated Q23.24 wavelength, mismatch flag, run mismatch count,
//   status and the echoed last flag. Coefficients, pixel base, term count
//   and tolerance are written over the APB port while the unit is idle.
//   Four Horner steps share a single 48x14 multiplier. Each item runs
//   a load step, then per Horner step a multiply and a round/add/saturate
//   step, then a compare step; a new request is taken only once the
//   previous item has left the compare step.
//   The next request is taken while the previous result is still waiting
//   in the output register. If the receiver stalls, the unit finishes the
//   pending item and holds in its compare step until the register frees.
//   Reset clears the sequencer, output valid, the mismatch counter and the
//   register file to its defaults (tolerance about 0.01).
// ----------------------------------------------------------------------------
`default_nettype none
`include "pixel_wavelength_poly_eval_unit_defines.svh"

module pixel_wavelength_poly_eval_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [pwpe_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [pwpe_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [pwpe_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                   pready,
  pwpe_req_if.sink                               req,
  pwpe_rsp_if.source                             rsp
);

  pwpe_pkg::cfg_t cfg;
  pwpe_pkg::cmd_t cmd;

  pwpe_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pwpe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  pwpe_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg            (cfg),
    .opcode         (req.opcode),
    .cell_req       (req.cell_req),
    .ref_wavelength (req.ref_wavelength),
    .last           (req.last),
    .wavelength     (rsp.wavelength),
    .mismatch       (rsp.mismatch),
    .diff_count     (rsp.diff_count),
    .status         (rsp.status),
    .run_end        (rsp.run_end)
  );

  // a failed item never reports a value or a mismatch
  `PWPE_ASSERT_IMP(a_fail_clean, clk, rst, rsp.valid && rsp.status, (rsp.wavelength == '0) && !rsp.mismatch)
  // a reported mismatch is always counted
  `PWPE_ASSERT_IMP(a_mis_counted, clk, rst, rsp.valid && rsp.mismatch, rsp.diff_count != '0)
  // one item in flight: no second request right after an accept
  `PWPE_ASSERT_NXT(a_one_item, clk, rst, req.valid && req.ready, !req.ready)

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: pixel wavelength polynomial unit
// Cells are fed over the request channel under several register settings,
// each result is predicted at acceptance and checked field by field.
// ----------------------------------------------------------------------------

module tb;
  import pwpe_pkg::*;

  localparam bit     OP_COMPUTE  = 1'b0;
  localparam bit     OP_VERIFY   = 1'b1;
  localparam longint WL_MAX      = 64'sd140737488355327;
  localparam longint WL_MIN      = -WL_MAX - 1;
  localparam int     TOL_DEFAULT = 167772;
  localparam int     COUNT_FULL  = 8191;
  localparam int     QUIET_LIMIT = 4000;
  localparam int     RAND_ITEMS  = 115;

  typedef struct {
    bit        op;
    bit [11:0] cell_idx;
    longint    refwl;
    bit        last;
  } cell_item_t;

  typedef struct {
    longint wl;
    bit     mis;
    int     cnt;
    bit     status;
    bit     run_end;
  } cell_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  pwpe_req_if req_ch ();
  pwpe_rsp_if rsp_ch ();

  pixel_wavelength_poly_eval_unit dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  always #10 clk = ~clk;

  // register shadow and run state of the predictor
  longint coef_sh [5];
  int     pix_sh;
  int     terms_sh;
  int     tol_sh;
  int     mis_count;

  cell_item_t   pending_cells [$];
  cell_result_t expected_wl [$];
  cell_item_t   drv_item;
  cell_result_t exp_r;

  int  src_idle;
  int  sink_idle;
  bit  hold_send;
  int  err_count;
  int  quiet;
  int  n_items, n_verify, n_flagged, n_fail, n_settings;

  function automatic longint sat48(longint v);
    if (v > WL_MAX) return WL_MAX;
    if (v < WL_MIN) return WL_MIN;
    return v;
  endfunction

  // Horner over all five coefficients, x/2^13 with round half up
  function automatic longint poly_eval(longint x);
    longint acc;
    longint p;
    acc = coef_sh[4];
    for (int k = 3; k >= 0; k--) begin
      p = acc * x + 64'sd4096;
      acc = sat48((p >>> FRAC_SHIFT) + coef_sh[k]);
    end
    return acc;
  endfunction

  function automatic longint wl_of(bit [11:0] cell_idx);
    return poly_eval(longint'(cell_idx) + pix_sh);
  endfunction

  function automatic cell_result_t predict_cell(bit op, logic [11:0] cell_idx,
                                                logic signed [47:0] refwl, bit last);
    cell_result_t r;
    longint d;
    r = '{wl: 0, mis: 0, cnt: 0, status: 0, run_end: 0};
    r.status = (terms_sh < 2);
    if (!r.status) begin
      r.wl = wl_of(cell_idx);
      if (op == OP_VERIFY) begin
        d = longint'(refwl) - r.wl;
        if (d < 0) d = -d;
        if (d > longint'(tol_sh)) begin
          r.mis = 1'b1;
          if (mis_count < COUNT_FULL) mis_count++;
        end
      end
    end
    r.cnt = mis_count;
    r.run_end = last;
    if (last) mis_count = 0;
    return r;
  endfunction

  // signed random value of magnitude below 2^bits
  function automatic longint rand_signed(int bits);
    longint v;
    v = {$urandom, $urandom};
    return v >>> (64 - bits);
  endfunction

  // request driver; expectations are formed at acceptance
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_wl.push_back(predict_cell(req_ch.opcode, req_ch.cell_req,
                                           req_ch.ref_wavelength, req_ch.last));
        n_items++;
        if (req_ch.opcode == OP_VERIFY) n_verify++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_cells.size() > 0 && !hold_send && $urandom_range(99) >= src_idle) begin
          drv_item = pending_cells.pop_front();
          req_ch.valid          <= 1'b1;
          req_ch.opcode         <= drv_item.op;
          req_ch.cell_req       <= drv_item.cell_idx;
          req_ch.ref_wavelength <= drv_item.refwl[47:0];
          req_ch.last           <= drv_item.last;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= sink_idle);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_wl.size() == 0) begin
          $error("result with no item outstanding");
          err_count++;
        end else begin
          exp_r = expected_wl.pop_front();
          if (exp_r.mis) n_flagged++;
          if (exp_r.status) n_fail++;
          if (rsp_ch.wavelength !== exp_r.wl[47:0]) begin
            $error("wavelength: expected %0d, got %0d", exp_r.wl, rsp_ch.wavelength);
            err_count++;
          end
          if (rsp_ch.mismatch !== exp_r.mis) begin
            $error("mismatch: expected %0d, got %0d", exp_r.mis, rsp_ch.mismatch);
            err_count++;
          end
          if (rsp_ch.diff_count !== CNT_W'(exp_r.cnt)) begin
            $error("diff_count: expected %0d, got %0d", exp_r.cnt, rsp_ch.diff_count);
            err_count++;
          end
          if (rsp_ch.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, rsp_ch.status);
            err_count++;
          end
          if (rsp_ch.run_end !== exp_r.run_end) begin
            $error("run_end: expected %0d, got %0d", exp_r.run_end, rsp_ch.run_end);
            err_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [63:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_COEF_0, REG_COEF_1, REG_COEF_2, REG_COEF_3, REG_COEF_4:
        coef_sh[idx] = longint'($signed(val[47:0]));
      REG_PIX_BASE:   pix_sh   = int'($signed(val[12:0]));
      REG_TERM_COUNT: terms_sh = int'(val[2:0]);
      REG_TOLERANCE:  tol_sh   = int'(val[23:0]);
      default: ;
    endcase
  endtask

  task automatic set_cfg(longint c0, longint c1, longint c2, longint c3, longint c4,
                         int pix, int terms, int tol);
    reg_write(REG_COEF_0, c0);
    reg_write(REG_COEF_1, c1);
    reg_write(REG_COEF_2, c2);
    reg_write(REG_COEF_3, c3);
    reg_write(REG_COEF_4, c4);
    reg_write(REG_PIX_BASE, longint'(pix));
    reg_write(REG_TERM_COUNT, longint'(terms));
    reg_write(REG_TOLERANCE, longint'(tol));
    n_settings++;
  endtask

  task automatic random_cfg();
    longint c [5];
    int pix, terms, tol, r;
    pix = $urandom_range(8191) - 4096;
    terms = ($urandom_range(3) == 0) ? $urandom_range(5) : $urandom_range(5, 2);
    r = $urandom_range(3);
    tol = (r == 0) ? 0 : (r == 1) ? $urandom_range(16777215) : $urandom_range(1 << 20);
    if ($urandom_range(3) == 0) begin
      // full range, saturates often
      for (int k = 0; k < 5; k++) c[k] = rand_signed(48);
    end else begin
      c[0] = rand_signed(45);
      c[1] = rand_signed(43);
      c[2] = rand_signed(41);
      c[3] = rand_signed(39);
      c[4] = rand_signed(37);
    end
    set_cfg(c[0], c[1], c[2], c[3], c[4], pix, terms, tol);
  endtask

  task automatic send(bit op, bit [11:0] cell_idx, longint refwl, bit last);
    pending_cells.push_back('{op: op, cell_idx: cell_idx, refwl: sat48(refwl), last: last});
  endtask

  // mostly verify items with references close to the tolerance edge
  task automatic random_item();
    bit [11:0] cell_idx;
    longint w, refwl;
    int r;
    cell_idx = 12'($urandom);
    w = wl_of(cell_idx);
    r = $urandom_range(99);
    if (r < 55)
      refwl = w + longint'($urandom_range(2 * tol_sh + 4)) - tol_sh - 2;
    else
      refwl = rand_signed(48);
    send(r < 80, cell_idx, refwl, $urandom_range(19) == 0);
  endtask

  // checked on the falling edge so that all clocked updates have settled
  task automatic wait_idle();
    while (pending_cells.size() > 0 || req_ch.valid || expected_wl.size() > 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    longint w;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_COMPUTE;
    req_ch.cell_req = '0;
    req_ch.ref_wavelength = '0;
    req_ch.last = 1'b0;
    rsp_ch.ready = 1'b0;
    hold_send = 1'b0;
    for (int k = 0; k < 5; k++) coef_sh[k] = 0;
    pix_sh = 0;
    terms_sh = 0;
    tol_sh = TOL_DEFAULT;
    mis_count = 0;
    src_idle = 11;
    sink_idle = 50;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: no terms set, status fail
    send(OP_VERIFY, 12'd5, 0, 1'b0);
    send(OP_COMPUTE, 12'd4095, WL_MAX, 1'b1);
    send(OP_VERIFY, 12'd0, WL_MIN, 1'b0);
    wait_idle();

    // one term is still a failure
    set_cfg(64'sd500 <<< 24, 64'sd2458 <<< 24, -(64'sd30 <<< 24), 64'sd4 <<< 24,
            -(64'sd1 <<< 23), 0, 1, TOL_DEFAULT);
    send(OP_VERIFY, 12'd100, 0, 1'b1);
    wait_idle();

    // realistic curve: tolerance edges and end of run
    reg_write(REG_TERM_COUNT, 64'd5);
    w = wl_of(12'd2048);
    send(OP_COMPUTE, 12'd0, 0, 1'b0);
    send(OP_COMPUTE, 12'd4095, 0, 1'b0);
    send(OP_VERIFY, 12'd2048, w + tol_sh, 1'b0);
    send(OP_VERIFY, 12'd2048, w - tol_sh, 1'b0);
    send(OP_VERIFY, 12'd2048, w + tol_sh + 1, 1'b0);
    send(OP_VERIFY, 12'd2048, w - tol_sh - 1, 1'b0);
    send(OP_VERIFY, 12'd17, WL_MAX, 1'b0);
    send(OP_VERIFY, 12'd17, WL_MIN, 1'b1);
    send(OP_VERIFY, 12'd17, wl_of(12'd17), 1'b0);
    wait_idle();

    // positive saturation, zero tolerance, largest base
    set_cfg(WL_MAX, WL_MAX, WL_MAX, WL_MAX, WL_MAX, 4095, 2, 0);
    send(OP_COMPUTE, 12'd4095, 0, 1'b0);
    send(OP_VERIFY, 12'd4095, WL_MAX, 1'b0);
    send(OP_VERIFY, 12'd0, WL_MAX - 1, 1'b1);
    wait_idle();

    // negative x with largest tolerance
    set_cfg(WL_MIN, WL_MIN, WL_MIN, WL_MIN, WL_MAX, -4096, 3, 16777215);
    send(OP_VERIFY, 12'd0, WL_MIN, 1'b0);
    w = wl_of(12'd4095);
    send(OP_VERIFY, 12'd4095, w + 16777215, 1'b0);
    send(OP_VERIFY, 12'd4095, w + 16777216, 1'b1);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        src_idle = 50;
        sink_idle = 11;
      end else if (ph == 4) begin
        src_idle = 0;
        sink_idle = 0;
      end
      random_cfg();
      repeat (RAND_ITEMS) random_item();
      if (ph == 2) begin
        // hold the sender until the unit drains completely
        while (pending_cells.size() > RAND_ITEMS / 2) @(posedge clk);
        hold_send <= 1'b1;
        @(posedge clk);
        while (req_ch.valid || expected_wl.size() > 0) @(posedge clk);
        hold_send <= 1'b0;
      end
      wait_idle();
    end
    repeat (12) @(posedge clk);

    $display("run: %0d items, %0d in verify mode, %0d flagged, %0d with fail status",
             n_items, n_verify, n_flagged, n_fail);
    $display("run: %0d register settings, stalls on both sides and a full drain pause",
             n_settings);
    if (err_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
